>>> rtl/core/cnv_pkg.sv
package cnv_pkg;

  // default sizing of the layer
  localparam int MAX_IN_CHANNELS  = 32;
  localparam int MAX_OUT_CHANNELS = 64;
  localparam int MAX_WIDTH        = 128;
  localparam int MAX_HEIGHT       = 128;

  // fixed constants of the scheme
  localparam int KERNEL_DIM  = 3;
  localparam int KERNEL_TAPS = 9;
  localparam int BLOCK_CH    = 16;
  localparam int PIX_MAX     = 255;

  // configuration port
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SHIFT = 3'd4;

  localparam logic [5:0] RST_IN_CHANNELS  = 6'd1;
  localparam logic [6:0] RST_OUT_CHANNELS = 7'd16;
  localparam logic [7:0] RST_FRAME_HEIGHT = 8'd128;
  localparam logic [7:0] RST_FRAME_WIDTH  = 8'd128;
  localparam logic [4:0] RST_RESULT_SHIFT = 5'd2;

  // input actions
  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_WEIGHT  = 2'd1;
  localparam logic [1:0] ACT_PIXEL   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ISSUE   = 5'b00010,
    ST_MAC     = 5'b00100,
    ST_POOL_RD = 5'b01000,
    ST_POOL_WR = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       ws_we;
    logic       ls_we;
    logic       tap_issue;
    logic       pad;
    logic       acc_en;
    logic       acc_first;
    logic       pool_rd;
    logic       pool_wr;
    logic       pool_first;
    logic       emit;
    logic       last;
    logic [4:0] shift;
    logic [5:0] out_channel;
    logic [5:0] pooled_row;
    logic [5:0] pooled_col;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic int eff_in_channels(logic [5:0] v, int mx);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > mx) r = mx;
    return r;
  endfunction

  function automatic int eff_out_channels(logic [6:0] v, int mx);
    int r;
    r = int'(v);
    if (r > mx) r = mx;
    r = r & ~(BLOCK_CH - 1);
    if (r < BLOCK_CH) r = BLOCK_CH;
    return r;
  endfunction

  function automatic int eff_dim(logic [7:0] v, int mx);
    int r;
    r = int'(v);
    if (r > mx) r = mx;
    r = r & ~1;
    if (r < 2) r = 2;
    return r;
  endfunction

  // residue of a small value modulo three
  function automatic logic [1:0] mod3(logic [2:0] v);
    logic [2:0] r;
    r = v;
    if (r >= 3'd6) r = r - 3'd6;
    else if (r >= 3'd3) r = r - 3'd3;
    return r[1:0];
  endfunction

endpackage

>>> rtl/core/cnv_in_if.sv
interface cnv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source(output valid, output action, output data_byte, input ready);
  modport sink(input valid, input action, input data_byte, output ready);
endinterface

>>> rtl/core/cnv_out_if.sv
interface cnv_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_channel;
  logic [5:0] pooled_row;
  logic [5:0] pooled_col;
  logic [7:0] pooled_value;
  logic       last;

  modport source(output valid, output out_channel, output pooled_row, output pooled_col,
                 output pooled_value, output last, input ready);
  modport sink(input valid, input out_channel, input pooled_row, input pooled_col,
               input pooled_value, input last, output ready);
endinterface

>>> rtl/core/cnv_ram.sv
module cnv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

>>> rtl/core/cnv_ctrl.sv
module cnv_ctrl #(
  parameter int MAX_IC = cnv_pkg::MAX_IN_CHANNELS,
  parameter int MAX_OC = cnv_pkg::MAX_OUT_CHANNELS,
  parameter int MAX_W  = cnv_pkg::MAX_WIDTH,
  parameter int MAX_H  = cnv_pkg::MAX_HEIGHT,
  localparam int WS_AW = $clog2(MAX_OC * MAX_IC * cnv_pkg::KERNEL_TAPS),
  localparam int LS_AW = $clog2(3 * MAX_W * MAX_IC),
  localparam int PL_AW = $clog2(MAX_OC * (MAX_W / 2))
) (
  input  logic                               clk,
  input  logic                               rst,
  cnv_in_if.sink                             request,
  input  logic                               cfg_write,
  input  logic [cnv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cnv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  cnv_pkg::dp_status_t                status,
  output cnv_pkg::dp_ctrl_t                  ctrl,
  output logic [WS_AW-1:0]                   ws_addr,
  output logic [LS_AW-1:0]                   ls_addr,
  output logic [PL_AW-1:0]                   pool_addr,
  output logic [7:0]                         wdata
);

  localparam int WS_DEPTH  = MAX_OC * MAX_IC * cnv_pkg::KERNEL_TAPS;
  localparam int WC_W      = $clog2(WS_DEPTH + 1);
  localparam int LS_ROW    = MAX_W * MAX_IC;
  localparam int POOL_COLS = MAX_W / 2;
  localparam int IC_W      = $clog2(MAX_IC + 1);
  localparam int OC_W      = $clog2(MAX_OC + 1);
  localparam int COL_W     = $clog2(MAX_W + 1);
  localparam int ROW_W     = $clog2(MAX_H + 1);
  localparam int BLK_SH    = $clog2(cnv_pkg::BLOCK_CH);
  localparam logic [1:0] TAP_END = 2'(cnv_pkg::KERNEL_DIM - 1);

  cnv_pkg::state_t state;

  logic [5:0] cfg_ic;
  logic [6:0] cfg_oc;
  logic [7:0] cfg_h;
  logic [7:0] cfg_w;
  logic [4:0] cfg_shift;

  logic [IC_W-1:0]  ic_eff;
  logic [OC_W-1:0]  oc_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] w_eff;

  logic [WC_W-1:0]  weight_count;
  logic [IC_W-1:0]  ch_pos;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [1:0]       row_slot;

  logic [ROW_W-1:0] pt_row;
  logic [COL_W-1:0] pt_col;
  logic [1:0]       pt_slot;
  logic [3:0]       pt_mask;

  logic [OC_W-1:0] oc_idx;
  logic [IC_W-1:0] ic_idx;
  logic [1:0]      tap_r;
  logic [1:0]      tap_c;

  assign ic_eff = IC_W'(cnv_pkg::eff_in_channels(cfg_ic, MAX_IC));
  assign oc_eff = OC_W'(cnv_pkg::eff_out_channels(cfg_oc, MAX_OC));
  assign h_eff  = ROW_W'(cnv_pkg::eff_dim(cfg_h, MAX_H));
  assign w_eff  = COL_W'(cnv_pkg::eff_dim(cfg_w, MAX_W));

  // input handshake
  logic accept;
  assign request.ready = (state == cnv_pkg::ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign wdata         = request.data_byte;

  // pixel position, restarted when it lies outside the frame
  logic             oob;
  logic [IC_W-1:0]  ch_cur;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [1:0]       slot_cur;
  logic [IC_W-1:0]  ch_inc;
  logic             chan_done, col_end, row_last;
  logic [3:0]       new_mask;

  assign oob      = (ch_pos >= ic_eff) || (col_pos >= w_eff) || (row_pos >= h_eff);
  assign ch_cur   = oob ? '0 : ch_pos;
  assign col_cur  = oob ? '0 : col_pos;
  assign row_cur  = oob ? '0 : row_pos;
  assign slot_cur = oob ? 2'd0 : row_slot;
  assign ch_inc   = ch_cur + IC_W'(1);
  assign chan_done = (ch_inc == ic_eff);
  assign col_end  = (col_cur == w_eff - COL_W'(1));
  assign row_last = (row_cur == h_eff - ROW_W'(1));

  // convolution points completed by this pixel, in output order
  assign new_mask[0] = (row_cur != '0) && (col_cur != '0);
  assign new_mask[1] = (row_cur != '0) && col_end;
  assign new_mask[2] = row_last && (col_cur != '0);
  assign new_mask[3] = row_last && col_end;

  // current point
  logic [1:0]       pidx;
  logic [3:0]       pbit;
  logic [ROW_W-1:0] pr;
  logic [COL_W-1:0] pc;
  logic [1:0]       pslot;

  always_comb begin
    if (pt_mask[0]) pidx = 2'd0;
    else if (pt_mask[1]) pidx = 2'd1;
    else if (pt_mask[2]) pidx = 2'd2;
    else pidx = 2'd3;
  end

  assign pbit  = 4'b0001 << pidx;
  assign pr    = pt_row - ((pidx[1] == 1'b0) ? ROW_W'(1) : ROW_W'(0));
  assign pc    = pt_col - (pidx[0] ? COL_W'(0) : COL_W'(1));
  assign pslot = (pidx[1] == 1'b0) ? cnv_pkg::mod3(3'(pt_slot) + 3'd2) : pt_slot;

  // tap position, offset by one so that padding shows as zero or past the edge
  logic [ROW_W:0] tr_u;
  logic [COL_W:0] tc_u;
  logic [1:0]     tslot;
  logic           pad;

  assign tr_u  = {1'b0, pr} + (ROW_W + 1)'(tap_r);
  assign tc_u  = {1'b0, pc} + (COL_W + 1)'(tap_c);
  assign tslot = cnv_pkg::mod3(3'(pslot) + 3'(tap_r) + 3'd2);
  assign pad   = (tr_u == '0) || (tr_u > {1'b0, h_eff}) ||
                 (tc_u == '0) || (tc_u > {1'b0, w_eff});

  logic last_tap, last_oc, need_out;
  assign last_tap = (ic_idx == ic_eff - IC_W'(1)) && (tap_r == TAP_END) && (tap_c == TAP_END);
  assign last_oc  = (oc_idx == oc_eff - OC_W'(1));
  assign need_out = pr[0] && pc[0];

  // address generation
  always_comb begin
    if (state == cnv_pkg::ST_IDLE) begin
      ws_addr = WS_AW'(weight_count);
      ls_addr = LS_AW'(int'(slot_cur) * LS_ROW + int'(col_cur) * MAX_IC + int'(ch_cur));
    end else begin
      ws_addr = WS_AW'(((int'(oc_idx >> BLK_SH) * int'(ic_eff) + int'(ic_idx))
                        * cnv_pkg::BLOCK_CH + int'(oc_idx[BLK_SH-1:0]))
                       * cnv_pkg::KERNEL_TAPS
                       + int'(tap_r) * cnv_pkg::KERNEL_DIM + int'(tap_c));
      ls_addr = LS_AW'(int'(tslot) * LS_ROW + (int'(tc_u) - 1) * MAX_IC + int'(ic_idx));
    end
  end

  assign pool_addr = PL_AW'(int'(oc_idx) * POOL_COLS + int'(pc >> 1));

  // commands to the datapath
  always_comb begin
    ctrl             = '0;
    ctrl.shift       = cfg_shift;
    ctrl.out_channel = 6'(oc_idx);
    ctrl.pooled_row  = 6'(pr >> 1);
    ctrl.pooled_col  = 6'(pc >> 1);
    ctrl.last        = last_oc;
    ctrl.pad         = pad;
    ctrl.pool_first  = !pr[0] && !pc[0];
    ctrl.acc_first   = (ic_idx == '0) && (tap_r == 2'd0) && (tap_c == 2'd0);
    case (state)
      cnv_pkg::ST_IDLE: begin
        ctrl.ws_we = accept && (request.action == cnv_pkg::ACT_WEIGHT) &&
                     (weight_count < WC_W'(WS_DEPTH));
        ctrl.ls_we = accept && (request.action == cnv_pkg::ACT_PIXEL);
      end
      cnv_pkg::ST_ISSUE:   ctrl.tap_issue = 1'b1;
      cnv_pkg::ST_MAC:     ctrl.acc_en = 1'b1;
      cnv_pkg::ST_POOL_RD: ctrl.pool_rd = 1'b1;
      cnv_pkg::ST_POOL_WR: begin
        ctrl.pool_wr = !need_out || status.out_free;
        ctrl.emit    = need_out && status.out_free;
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ic    <= cnv_pkg::RST_IN_CHANNELS;
      cfg_oc    <= cnv_pkg::RST_OUT_CHANNELS;
      cfg_h     <= cnv_pkg::RST_FRAME_HEIGHT;
      cfg_w     <= cnv_pkg::RST_FRAME_WIDTH;
      cfg_shift <= cnv_pkg::RST_RESULT_SHIFT;
    end else if (cfg_write) begin
      case (cfg_index)
        cnv_pkg::CFG_IN_CHANNELS:  cfg_ic    <= cfg_data[5:0];
        cnv_pkg::CFG_OUT_CHANNELS: cfg_oc    <= cfg_data[6:0];
        cnv_pkg::CFG_FRAME_HEIGHT: cfg_h     <= cfg_data;
        cnv_pkg::CFG_FRAME_WIDTH:  cfg_w     <= cfg_data;
        cnv_pkg::CFG_RESULT_SHIFT: cfg_shift <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cnv_pkg::ST_IDLE;
      weight_count <= '0;
      ch_pos       <= '0;
      col_pos      <= '0;
      row_pos      <= '0;
      row_slot     <= 2'd0;
      pt_mask      <= '0;
      oc_idx       <= '0;
      ic_idx       <= '0;
      tap_r        <= 2'd0;
      tap_c        <= 2'd0;
    end else begin
      case (state)
        cnv_pkg::ST_IDLE: begin
          if (accept) begin
            case (request.action)
              cnv_pkg::ACT_RESTART: begin
                weight_count <= '0;
                ch_pos       <= '0;
                col_pos      <= '0;
                row_pos      <= '0;
                row_slot     <= 2'd0;
              end
              cnv_pkg::ACT_WEIGHT: begin
                if (weight_count < WC_W'(WS_DEPTH)) weight_count <= weight_count + WC_W'(1);
              end
              cnv_pkg::ACT_PIXEL: begin
                ch_pos   <= chan_done ? '0 : ch_inc;
                col_pos  <= col_cur;
                row_pos  <= row_cur;
                row_slot <= slot_cur;
                if (chan_done) begin
                  pt_row  <= row_cur;
                  pt_col  <= col_cur;
                  pt_slot <= slot_cur;
                  pt_mask <= new_mask;
                  oc_idx  <= '0;
                  ic_idx  <= '0;
                  tap_r   <= 2'd0;
                  tap_c   <= 2'd0;
                  if (new_mask != 4'd0) state <= cnv_pkg::ST_ISSUE;
                  if (col_end) begin
                    col_pos <= '0;
                    if (row_last) begin
                      row_pos  <= '0;
                      row_slot <= 2'd0;
                    end else begin
                      row_pos  <= row_cur + ROW_W'(1);
                      row_slot <= cnv_pkg::mod3(3'(slot_cur) + 3'd1);
                    end
                  end else begin
                    col_pos <= col_cur + COL_W'(1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        cnv_pkg::ST_ISSUE: state <= cnv_pkg::ST_MAC;
        cnv_pkg::ST_MAC: begin
          // step through taps, then input channels
          if (tap_c == TAP_END) begin
            tap_c <= 2'd0;
            if (tap_r == TAP_END) begin
              tap_r  <= 2'd0;
              ic_idx <= last_tap ? '0 : ic_idx + IC_W'(1);
            end else begin
              tap_r <= tap_r + 2'd1;
            end
          end else begin
            tap_c <= tap_c + 2'd1;
          end
          state <= last_tap ? cnv_pkg::ST_POOL_RD : cnv_pkg::ST_ISSUE;
        end
        cnv_pkg::ST_POOL_RD: state <= cnv_pkg::ST_POOL_WR;
        cnv_pkg::ST_POOL_WR: begin
          if (!need_out || status.out_free) begin
            if (last_oc) begin
              oc_idx  <= '0;
              pt_mask <= pt_mask & ~pbit;
              state   <= ((pt_mask & ~pbit) == 4'd0) ? cnv_pkg::ST_IDLE : cnv_pkg::ST_ISSUE;
            end else begin
              oc_idx <= oc_idx + OC_W'(1);
              state  <= cnv_pkg::ST_ISSUE;
            end
          end
        end
        default: state <= cnv_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/cnv_dp.sv
module cnv_dp #(
  parameter int MAX_IC = cnv_pkg::MAX_IN_CHANNELS,
  parameter int MAX_OC = cnv_pkg::MAX_OUT_CHANNELS,
  parameter int MAX_W  = cnv_pkg::MAX_WIDTH,
  localparam int WS_AW = $clog2(MAX_OC * MAX_IC * cnv_pkg::KERNEL_TAPS),
  localparam int LS_AW = $clog2(3 * MAX_W * MAX_IC),
  localparam int PL_AW = $clog2(MAX_OC * (MAX_W / 2))
) (
  input  logic                clk,
  input  logic                rst,
  input  cnv_pkg::dp_ctrl_t   ctrl,
  input  logic [WS_AW-1:0]    ws_addr,
  input  logic [LS_AW-1:0]    ls_addr,
  input  logic [PL_AW-1:0]    pool_addr,
  input  logic [7:0]          wdata,
  output cnv_pkg::dp_status_t status,
  cnv_out_if.source           result
);

  localparam int ACC_W = 16 + $clog2(MAX_IC * cnv_pkg::KERNEL_TAPS);

  logic [7:0] ws_rdata, ls_rdata, pool_rdata, pool_wdata;

  cnv_ram #(.WIDTH(8), .DEPTH(MAX_OC * MAX_IC * cnv_pkg::KERNEL_TAPS)) u_weight_ram (
    .clk(clk), .we(ctrl.ws_we), .re(ctrl.tap_issue), .addr(ws_addr),
    .wdata(wdata), .rdata(ws_rdata)
  );

  cnv_ram #(.WIDTH(8), .DEPTH(3 * MAX_W * MAX_IC)) u_line_ram (
    .clk(clk), .we(ctrl.ls_we), .re(ctrl.tap_issue), .addr(ls_addr),
    .wdata(wdata), .rdata(ls_rdata)
  );

  cnv_ram #(.WIDTH(8), .DEPTH(MAX_OC * (MAX_W / 2))) u_pool_ram (
    .clk(clk), .we(ctrl.pool_wr), .re(ctrl.pool_rd), .addr(pool_addr),
    .wdata(pool_wdata), .rdata(pool_rdata)
  );

  // padding flag travels with the read
  logic pad_q;
  always_ff @(posedge clk) begin
    if (ctrl.tap_issue) pad_q <= ctrl.pad;
  end

  // multiply-accumulate
  logic [7:0]               pix;
  logic signed [16:0]       prod;
  logic signed [ACC_W-1:0]  acc;

  assign pix  = pad_q ? 8'd0 : ls_rdata;
  assign prod = $signed(ws_rdata) * $signed({1'b0, pix});

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) acc <= ctrl.acc_first ? ACC_W'(prod) : acc + ACC_W'(prod);
  end

  // relu, shift and clamp
  logic [ACC_W-1:0] shifted;
  logic [7:0]       clamped, val_q;

  assign shifted = (acc > 0) ? (ACC_W'(acc) >> ctrl.shift) : '0;
  assign clamped = (shifted > ACC_W'(cnv_pkg::PIX_MAX)) ? 8'(cnv_pkg::PIX_MAX) : shifted[7:0];

  always_ff @(posedge clk) begin
    if (ctrl.pool_rd) val_q <= clamped;
  end

  // running 2x2 maximum
  assign pool_wdata = (ctrl.pool_first || (val_q > pool_rdata)) ? val_q : pool_rdata;

  // output register
  assign status.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctrl.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      result.out_channel  <= ctrl.out_channel;
      result.pooled_row   <= ctrl.pooled_row;
      result.pooled_col   <= ctrl.pooled_col;
      result.pooled_value <= pool_wdata;
      result.last         <= ctrl.last;
    end
  end

endmodule

>>> rtl/core/conv3x3_relu_maxpool_layer.sv
// 3x3 convolution layer with relu, shift, clamp and 2x2 max pooling on int8 weights and
// 8-bit pixels. Restart and weight bytes, and a pixel byte that does not finish its channel
// group, leave the sequencer idle; a pixel byte that finishes it completes up to four
// convolution points (two at a row end, four at the frame corner). Each point walks every
// output channel through every tap and input channel on the single multiply-accumulate unit
// and the single-port weight and line memories, then reads and writes the pool memory.
// A pooled result waits in an output register; the sequencer stalls only when a new result
// meets a full register. The weight, line and pool memories need no clearing after reset.
module conv3x3_relu_maxpool_layer #(
  parameter int MAX_IC = cnv_pkg::MAX_IN_CHANNELS,
  parameter int MAX_OC = cnv_pkg::MAX_OUT_CHANNELS,
  parameter int MAX_W  = cnv_pkg::MAX_WIDTH,
  parameter int MAX_H  = cnv_pkg::MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  cnv_in_if.sink                         request,
  cnv_out_if.source                      result,
  input  logic                           cfg_write,
  input  logic [cnv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cnv_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int WS_AW = $clog2(MAX_OC * MAX_IC * cnv_pkg::KERNEL_TAPS);
  localparam int LS_AW = $clog2(3 * MAX_W * MAX_IC);
  localparam int PL_AW = $clog2(MAX_OC * (MAX_W / 2));

  cnv_pkg::dp_ctrl_t   ctrl;
  cnv_pkg::dp_status_t status;
  logic [WS_AW-1:0]    ws_addr;
  logic [LS_AW-1:0]    ls_addr;
  logic [PL_AW-1:0]    pool_addr;
  logic [7:0]          wdata;

  cnv_ctrl #(.MAX_IC(MAX_IC), .MAX_OC(MAX_OC), .MAX_W(MAX_W), .MAX_H(MAX_H)) u_ctrl (
    .clk(clk), .rst(rst), .request(request),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .status(status), .ctrl(ctrl), .ws_addr(ws_addr), .ls_addr(ls_addr),
    .pool_addr(pool_addr), .wdata(wdata)
  );

  cnv_dp #(.MAX_IC(MAX_IC), .MAX_OC(MAX_OC), .MAX_W(MAX_W)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .ws_addr(ws_addr), .ls_addr(ls_addr),
    .pool_addr(pool_addr), .wdata(wdata), .status(status), .result(result)
  );

endmodule

>>> rtl/core/cnv_checker.sv
module cnv_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_action,
  input logic       res_valid,
  input logic       res_ready,
  input logic [5:0] res_channel,
  input logic [7:0] res_value,
  input logic       res_last
);

  // a stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_channel) && $stable(res_value)
      && $stable(res_last))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // after a restart or weight byte the input is ready again in the next cycle
  a_short_items: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action != cnv_pkg::ACT_PIXEL) |=> req_ready)
    else $error("non-pixel transfer blocked input");

  // a non-pixel transfer never produces a new result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action != cnv_pkg::ACT_PIXEL) && (!res_valid || res_ready)
      |=> !res_valid)
    else $error("result without pixel");

endmodule

bind conv3x3_relu_maxpool_layer cnv_checker u_checker (
  .clk(clk), .rst(rst),
  .req_valid(request.valid), .req_ready(request.ready), .req_action(request.action),
  .res_valid(result.valid), .res_ready(result.ready), .res_channel(result.out_channel),
  .res_value(result.pooled_value), .res_last(result.last)
);
